// ----- design/cmas_pkg.sv -----
// Shared types and constants for the centered moving average block.
`default_nettype none
package cmas_pkg;

  localparam int SEEN_W     = 8;
  localparam int K_W        = 9;
  localparam int FRAC_SHIFT = 12;
  localparam int CNT_W      = 8;
  localparam int WW_W       = 7;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_WR   = 8'b0000_0010,
    ST_CEN  = 8'b0000_0100,
    ST_CAP  = 8'b0000_1000,
    ST_SUM  = 8'b0001_0000,
    ST_MUL  = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

endpackage
`default_nettype wire

// ----- design/cmas_ring.sv -----
// Sample ring memory: one write port, one registered read port.
`default_nettype none
module cmas_ring #(
  parameter int AW = 7,
  parameter int DW = 50
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/cmas_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module cmas_div #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic             qbit;

  assign trial = {rem_r, q_r[NUM_W-1]};
  assign qbit  = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quot  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CW'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
      cnt_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], qbit};
      rem_r <= qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      cnt_r <= cnt_r + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- design/centered_moving_average_na_skip.sv -----
// Centered moving average with missing-sample skipping: top level.
// Input words carry a sample and its weight; output words carry the mean of
// the valid samples in a centered window, divided by the center weight.
// cfg_wr_en/cfg_wr_data set the window width (half-width = width/2); write
// it only while the block is idle.
// One input word is taken at a time (in_tready high only when idle). Each
// result reads the window from the ring memory one entry per cycle
// (reach up to 2*half-width), then a bit-serial divider computes the
// quotient (skipped for a missing result). A word with no result goes
// back to idle after its write. Results lag the input by the half-width;
// a word with in_tlast flushes all pending results, the final one marked
// by out_tlast.
// The result sits in an output register; when the receiver stalls the
// block waits with the next result until out_tready.
// Reset (rst_n low, synchronous) clears control, sequence count, ring
// pointer and sets the window width to 3. The ring needs no clearing.
`default_nettype none
module centered_moving_average_na_skip #(
  parameter int MAX_HALF_WINDOW = 63,
  parameter int SAMPLE_BITS     = 32,
  parameter int WEIGHT_BITS     = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  // [SAMPLE_BITS-1:0] sample_value, then weight_value, zero padded
  input  wire logic [((SAMPLE_BITS+WEIGHT_BITS+7)/8)*8-1:0] in_tdata,
  // [0] sample_missing, [1] weight_missing
  input  wire logic [1:0] in_tuser,
  input  wire logic       in_tlast,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  // [SAMPLE_BITS-1:0] average_value, zero padded
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  // [0] average_missing, [1] average_saturated
  output logic [1:0] out_tuser,
  output logic       out_tlast,
  input  wire logic  cfg_wr_en,
  input  wire logic [cmas_pkg::WW_W-1:0] cfg_wr_data
);

  localparam int HW      = $clog2(MAX_HALF_WINDOW + 1);
  localparam int RING_AW = $clog2(2 * MAX_HALF_WINDOW + 2);
  localparam int DW      = SAMPLE_BITS + WEIGHT_BITS + 2;
  localparam int SUM_W   = SAMPLE_BITS + cmas_pkg::CNT_W;
  localparam int NUM_W   = SUM_W + cmas_pkg::FRAC_SHIFT;
  localparam int D_W     = cmas_pkg::CNT_W + WEIGHT_BITS;
  localparam int KW      = cmas_pkg::K_W;
  localparam int OD_W    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam logic [NUM_W-1:0] NEG_LIM =
    {{(NUM_W - SAMPLE_BITS){1'b0}}, 1'b1, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic [NUM_W-1:0] POS_LIM = NEG_LIM - NUM_W'(1);

  cmas_pkg::state_t state_r;
  logic [cmas_pkg::WW_W-1:0]   ww_r;
  logic [RING_AW-1:0]          wp_r;
  logic [cmas_pkg::SEEN_W-1:0] seen_r;
  logic [HW-1:0]               b_r;
  logic                        last_r;
  logic [KW-1:0]               k_r;
  logic [KW-1:0]               reach_r;
  logic                        pend_r;
  logic signed [SUM_W-1:0]     sum_r;
  logic [cmas_pkg::CNT_W-1:0]  cnt_r;
  logic [WEIGHT_BITS-1:0]      cw_r;
  logic                        cwmiss_r;
  logic                        neg_r;
  logic [SAMPLE_BITS-1:0]      res_val_r;
  logic                        res_miss_r;
  logic                        res_sat_r;
  logic [SAMPLE_BITS-1:0]      out_val_r;
  logic                        out_miss_r;
  logic                        out_sat_r;
  logic                        out_last_r;
  logic                        out_valid_r;

  logic [HW-1:0]      h;
  logic [5:0]         hraw;
  logic [RING_AW-1:0] newest;
  logic               in_acc;
  logic               mem_re;
  logic [RING_AW-1:0] mem_raddr;
  logic [DW-1:0]      mem_wdata;
  logic [DW-1:0]      mem_q;
  logic               issue;
  logic [KW-1:0]      bh;
  logic [KW-1:0]      sm1;
  logic [SUM_W-1:0]   mag;
  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   quot;
  logic [NUM_W-1:0]   lim;
  logic               sat;
  logic [SAMPLE_BITS-1:0] full;
  logic               can_out;

  assign hraw   = ww_r[cmas_pkg::WW_W-1:1];
  assign h      = (32'(hraw) > MAX_HALF_WINDOW) ? HW'(MAX_HALF_WINDOW) : HW'(hraw);
  assign newest = wp_r - 1'b1;
  assign in_tready = (state_r == cmas_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign mem_wdata = {in_tuser[1], in_tdata[SAMPLE_BITS +: WEIGHT_BITS],
                      !in_tuser[0] && !in_tuser[1], in_tdata[SAMPLE_BITS-1:0]};
  assign issue = (state_r == cmas_pkg::ST_SUM) && (k_r <= reach_r);
  assign bh    = KW'(b_r) + KW'(h);
  assign sm1   = KW'(seen_r) - KW'(1);
  assign mag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign div_start = (state_r == cmas_pkg::ST_MUL) &&
                     !(cnt_r == '0 || cwmiss_r || cw_r == '0);
  assign lim   = neg_r ? NEG_LIM : POS_LIM;
  assign sat   = quot > lim;
  assign full  = sat ? lim[SAMPLE_BITS-1:0] : quot[SAMPLE_BITS-1:0];
  assign can_out = !out_valid_r || out_tready;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = newest - RING_AW'(k_r);
    if (state_r == cmas_pkg::ST_CEN) begin
      mem_re    = 1'b1;
      mem_raddr = newest - RING_AW'(b_r);
    end else if (issue) begin
      mem_re = 1'b1;
    end
  end

  cmas_ring #(.AW(RING_AW), .DW(DW)) u_ring (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp_r),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  cmas_div #(.NUM_W(NUM_W), .DEN_W(D_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({mag, {cmas_pkg::FRAC_SHIFT{1'b0}}}),
    .den   (D_W'(cnt_r) * D_W'(cw_r)),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cmas_pkg::ST_IDLE;
      ww_r        <= cmas_pkg::WW_W'(3);
      wp_r        <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ww_r <= cfg_wr_data;
      end
      if (state_r == cmas_pkg::ST_OUT && can_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        cmas_pkg::ST_IDLE: begin
          if (in_acc) begin
            wp_r   <= wp_r + 1'b1;
            if (seen_r != '1) begin
              seen_r <= seen_r + 1'b1;
            end
            state_r <= cmas_pkg::ST_WR;
          end
        end
        cmas_pkg::ST_WR: begin
          if (last_r) begin
            state_r <= cmas_pkg::ST_CEN;
          end else if (KW'(seen_r) > KW'(h)) begin
            state_r <= cmas_pkg::ST_CEN;
          end else begin
            state_r <= cmas_pkg::ST_IDLE;
          end
        end
        cmas_pkg::ST_CEN: state_r <= cmas_pkg::ST_CAP;
        cmas_pkg::ST_CAP: state_r <= cmas_pkg::ST_SUM;
        cmas_pkg::ST_SUM: begin
          if (!issue && !pend_r) begin
            state_r <= cmas_pkg::ST_MUL;
          end
        end
        cmas_pkg::ST_MUL: begin
          state_r <= div_start ? cmas_pkg::ST_DIV : cmas_pkg::ST_OUT;
        end
        cmas_pkg::ST_DIV: begin
          if (div_done) begin
            state_r <= cmas_pkg::ST_OUT;
          end
        end
        cmas_pkg::ST_OUT: begin
          if (can_out) begin
            if (last_r && b_r != '0) begin
              state_r <= cmas_pkg::ST_CEN;
            end else begin
              if (last_r) begin
                seen_r <= '0;
              end
              state_r <= cmas_pkg::ST_IDLE;
            end
          end
        end
        default: state_r <= cmas_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= issue;
    unique case (state_r)
      cmas_pkg::ST_IDLE: begin
        last_r <= in_tlast;
      end
      cmas_pkg::ST_WR: begin
        b_r <= (KW'(h) < sm1) ? h : HW'(sm1);
      end
      cmas_pkg::ST_CEN: begin
        reach_r <= (bh < sm1) ? bh : sm1;
      end
      cmas_pkg::ST_CAP: begin
        cw_r     <= mem_q[SAMPLE_BITS+1 +: WEIGHT_BITS];
        cwmiss_r <= mem_q[DW-1];
        k_r      <= '0;
        sum_r    <= '0;
        cnt_r    <= '0;
      end
      cmas_pkg::ST_SUM: begin
        if (issue) begin
          k_r <= k_r + 1'b1;
        end
        if (pend_r && mem_q[SAMPLE_BITS]) begin
          sum_r <= sum_r + SUM_W'($signed(mem_q[SAMPLE_BITS-1:0]));
          cnt_r <= cnt_r + 1'b1;
        end
      end
      cmas_pkg::ST_MUL: begin
        neg_r      <= sum_r[SUM_W-1];
        res_miss_r <= !div_start;
        res_val_r  <= '0;
        res_sat_r  <= 1'b0;
      end
      cmas_pkg::ST_DIV: begin
        if (div_done) begin
          res_val_r <= neg_r ? -full : full;
          res_sat_r <= sat;
        end
      end
      cmas_pkg::ST_OUT: begin
        if (can_out) begin
          out_val_r  <= res_val_r;
          out_miss_r <= res_miss_r;
          out_sat_r  <= res_sat_r;
          out_last_r <= last_r && b_r == '0;
          if (last_r && b_r != '0) begin
            b_r <= b_r - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OD_W'(out_val_r);
  assign out_tuser  = {out_sat_r, out_miss_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for the centered moving average block: predictor, scoreboard and stimulus.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = 32;
  localparam int WB = 16;
  localparam int HMAX = 63;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [SB-1:0] value;
    logic          missing;
    logic          sat;
    logic          last;
  } avg_t;

  class avg_scoreboard;
    longint    vals[128];
    bit        ok[128];
    bit [WB-1:0] wts[64];
    bit        wmiss[64];
    int        seen;
    int        wp;
    int        width;
    avg_t      pending[$];
    int        errors;
    int        checked;

    function void clear();
      seen = 0; wp = 0; width = 3; pending.delete();
    endfunction

    function avg_t window_avg(int b, int h, bit last);
      int newest, cs, reach, cnt;
      longint s, q1, r, d, full, lim;
      bit neg;
      avg_t o;
      newest = (wp + 127) % 128;
      cs = (newest + 128 - b) % 128;
      reach = b + h;
      if (reach > seen - 1) reach = seen - 1;
      s = 0; cnt = 0;
      for (int k = 0; k <= reach; k++) begin
        if (ok[(newest + 128 - k) % 128]) begin
          s += vals[(newest + 128 - k) % 128]; cnt++;
        end
      end
      o = '0;
      o.last = last;
      if (cnt == 0 || wmiss[cs % 64] || wts[cs % 64] == 0) begin
        o.missing = 1;
        return o;
      end
      neg = s < 0;
      if (neg) s = -s;
      d = longint'(cnt) * wts[cs % 64];
      q1 = s / d; r = s % d;
      lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
      if (q1 > (lim >> 12)) begin
        o.sat = 1; full = lim;
      end else begin
        full = (q1 << 12) + ((r << 12) / d);
        if (full > lim) begin
          o.sat = 1; full = lim;
        end
      end
      o.value = SB'(neg ? -full : full);
      return o;
    endfunction

    function void note_input(logic [SB-1:0] v, bit sm, logic [WB-1:0] w, bit wm, bit last);
      int h, b;
      h = width / 2;
      if (h > HMAX) h = HMAX;
      vals[wp] = longint'($signed(v));
      ok[wp] = !sm && !wm;
      wts[wp % 64] = w;
      wmiss[wp % 64] = wm;
      wp = (wp + 1) % 128;
      if (seen < 255) seen++;
      if (!last) begin
        if (seen > h) pending.push_back(window_avg(h, h, 0));
      end else begin
        b = (h < seen - 1) ? h : seen - 1;
        for (int i = b; i >= 0; i--) pending.push_back(window_avg(i, h, i == 0));
        seen = 0;
      end
    endfunction

    function void check_result(avg_t got);
      avg_t exp;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        $display("%0t: mismatch exp %h/%b/%b/%b got %h/%b/%b/%b",
                 $time, exp.value, exp.missing, exp.sat, exp.last,
                 got.value, got.missing, got.sat, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [SB+WB-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [SB-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_wr_en = 0;
  logic [6:0] cfg_wr_data = '0;

  avg_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;
  longint cycles = 0;
  int sent = 0;

  centered_moving_average_na_skip dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_wr_en, .cfg_wr_data
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready)
      sb.check_result({out_tdata, out_tuser[0], out_tuser[1], out_tlast});
  end

  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_word(logic [SB-1:0] v, bit sm, logic [WB-1:0] w, bit wm, bit last);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {w, v};
    in_tuser <= {wm, sm};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(v, sm, w, wm, last);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_width(int w);
    drain();
    cfg_wr_en <= 1;
    cfg_wr_data <= 7'(w);
    @(negedge clk);
    cfg_wr_en <= 0;
    sb.width = w;
  endtask

  task automatic random_seq(int len, int mode);
    logic [SB-1:0] v;
    logic [WB-1:0] w;
    for (int i = 0; i < len; i++) begin
      v = $urandom();
      if (mode == 0) v = $signed(v) >>> $urandom_range(20);
      w = (mode == 1) ? WB'($urandom_range(3)) : WB'($urandom());
      if ($urandom_range(3) == 0) w = w >> $urandom_range(15);
      send_word(v, $urandom_range(9) == 0, w, $urandom_range(9) == 0, i == len - 1);
    end
  endtask

  initial begin
    int widths[6] = '{3, 0, 127, 1, 8, 21};
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: extremes, missing flags, zero weight, short sequence
    send_word(32'h7fff_ffff, 0, 16'h0001, 0, 0);
    send_word(32'h7fff_ffff, 0, 16'h0001, 0, 0);
    send_word(32'h8000_0000, 0, 16'h0001, 0, 0);
    send_word(32'h8000_0000, 0, 16'hffff, 0, 0);
    send_word(32'h0001_0000, 1, 16'h1000, 0, 0);
    send_word(32'h0001_0000, 0, 16'h1000, 1, 0);
    send_word(32'hffff_0000, 0, 16'h0000, 0, 0);
    send_word(32'h0000_0000, 1, 16'h1000, 1, 1);
    send_word(32'h1234_5678, 0, 16'h1000, 0, 1);
    send_word(32'h8000_0000, 0, 16'h0001, 0, 0);
    send_word(32'h8000_0000, 1, 16'h0001, 0, 1);
    set_width(7);
    send_word(32'h0002_0000, 0, 16'h2000, 0, 0);
    send_word(32'h0003_0000, 0, 16'h0800, 0, 1);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 62 : 37) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 62 : 37) : 0;
      foreach (widths[j]) begin
        set_width((ph == 3 && j == 5) ? $urandom_range(127) : widths[j]);
        random_seq($urandom_range(1, 12), $urandom_range(2));
      end
      if (ph == 0) begin
        // narrow window so each word yields a result and the input backs up
        set_width(3);
        hold_off = 400;
        random_seq(20, 0);
      end
    end
    set_width(3);
    random_seq(70, 0);
    drain();
    $display("sent %0d words, checked %0d results, widths 0..127 and long stall covered",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial sb.clear();
endmodule
`default_nettype wire

// ----- filelist.f -----
design/cmas_pkg.sv
design/cmas_ring.sv
design/cmas_div.sv
design/centered_moving_average_na_skip.sv
sim/tb_top.sv
